@@ hw/rtl/sbct_pkg.sv @@
// ----------------------------------------------------------------------------
// sbct_pkg
// Shared constants, types and helpers of the swept box contact time block.
// ----------------------------------------------------------------------------
package sbct_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int COORD_W    = 32;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int NQ_W       = DIFF_W + FRAC_BITS;
  localparam int REM_W      = DIFF_W + 1;
  localparam int DIV_STEPS  = NQ_W;
  localparam int SPEED_W    = 16;
  localparam int TIME_W     = 31;
  localparam int CFG_IDX_W  = 1;
  localparam int LANES      = 4;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_TIME = 1'd1;

  localparam logic [SPEED_W-1:0] MIN_SPEED_RST  = 16'd66;
  localparam logic [TIME_W-1:0]  FRAME_TIME_RST = 31'd65536;

  // Lane order: x entry, x leave, y entry, y leave.
  localparam int LANE_XE = 0;
  localparam int LANE_XL = 1;
  localparam int LANE_YE = 2;
  localparam int LANE_YL = 3;

  typedef struct packed {
    logic             x_static;
    logic             x_ok;
    logic             y_static;
    logic             y_ok;
    logic [LANES-1:0] neg;
  } side_t;

  // Saturate a quotient magnitude with its sign to the signed 32-bit range.
  function automatic logic signed [COORD_W-1:0] sat_q(input logic [NQ_W-1:0] q,
                                                      input logic neg);
    logic [COORD_W-1:0] mag;
    mag = q[COORD_W-1:0];
    if (!neg) begin
      if (|q[NQ_W-1:COORD_W-1]) sat_q = {1'b0, {(COORD_W-1){1'b1}}};
      else                     sat_q = $signed(mag);
    end else begin
      if ((|q[NQ_W-1:COORD_W]) || (q[COORD_W-1] && (|q[COORD_W-2:0])))
        sat_q = {1'b1, {(COORD_W-1){1'b0}}};
      else
        sat_q = $signed(-mag);
    end
  endfunction

endpackage

@@ hw/rtl/sbct_in_if.sv @@
// ----------------------------------------------------------------------------
// sbct_in_if
// Box pair input channel: two boxes with bounds and velocities per beat.
// ----------------------------------------------------------------------------
interface sbct_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] a_min_x;
  logic [31:0] a_max_x;
  logic [31:0] a_min_y;
  logic [31:0] a_max_y;
  logic [31:0] b_min_x;
  logic [31:0] b_max_x;
  logic [31:0] b_min_y;
  logic [31:0] b_max_y;
  logic [31:0] a_vel_x;
  logic [31:0] a_vel_y;
  logic [31:0] b_vel_x;
  logic [31:0] b_vel_y;

  modport source (output valid, a_min_x, a_max_x, a_min_y, a_max_y, b_min_x, b_max_x,
                  b_min_y, b_max_y, a_vel_x, a_vel_y, b_vel_x, b_vel_y, input ready);
  modport sink   (input valid, a_min_x, a_max_x, a_min_y, a_max_y, b_min_x, b_max_x,
                  b_min_y, b_max_y, a_vel_x, a_vel_y, b_vel_x, b_vel_y, output ready);
endinterface

@@ hw/rtl/sbct_out_if.sv @@
// ----------------------------------------------------------------------------
// sbct_out_if
// Contact result channel: hit flag and contact time per beat.
// ----------------------------------------------------------------------------
interface sbct_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [30:0] contact_time;

  modport source (output valid, hit, contact_time, input ready);
  modport sink   (input valid, hit, contact_time, output ready);
endinterface

@@ hw/rtl/sbct_cfg_if.sv @@
// ----------------------------------------------------------------------------
// sbct_cfg_if
// Register write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
interface sbct_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [30:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/swept_box_contact_time.sv @@
// ----------------------------------------------------------------------------
// swept_box_contact_time
// Earliest contact time of two moving axis-aligned boxes, Q15.16, pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one beat carries a box pair (bounds and velocities of A and B).
//   out_ch : one beat per input beat, in order: hit and contact_time.
//   cfg_ch : register writes (0: min_speed, 1: frame_time); always ready.
//            Write only while no pair is in flight.
// Throughput: one pair per cycle while out_ch does not stall. Pipeline from
//   accept to out valid, through 52 registers: one setup stage for speeds and
//   bound gaps, 49 restoring divider stages (one quotient bit each, four
//   dividers side by side), one saturate and order stage, one output register.
// Stall: the whole pipeline holds while a result waits on out_ch; in_ch
//   ready drops then, and nothing is lost or repeated.
// Reset: rst_n (synchronous, active low) empties the pipeline and sets
//   min_speed to 66 and frame_time to 1.0.
// ----------------------------------------------------------------------------
module swept_box_contact_time (
  input logic         clk,
  input logic         rst_n,
  sbct_in_if.sink     in_ch,
  sbct_out_if.source  out_ch,
  sbct_cfg_if.sink    cfg_ch
);
  import sbct_pkg::*;

  logic [SPEED_W-1:0] min_speed_r;
  logic [TIME_W-1:0]  frame_time_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_speed_r  <= MIN_SPEED_RST;
      frame_time_r <= FRAME_TIME_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_MIN_SPEED:  min_speed_r  <= cfg_ch.data[SPEED_W-1:0];
        REG_FRAME_TIME: frame_time_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_vld_r;
  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // ---------------- setup stage ----------------
  typedef struct packed {
    logic              is_static;
    logic              ok;
    logic [DIFF_W-1:0] den;
    logic [NQ_W-1:0]   ne;
    logic [NQ_W-1:0]   nl;
    logic              neg_e;
    logic              neg_l;
  } axis_t;

  function automatic axis_t axis_prep(input logic [COORD_W-1:0] amin,
      input logic [COORD_W-1:0] amax, input logic [COORD_W-1:0] bmin,
      input logic [COORD_W-1:0] bmax, input logic [COORD_W-1:0] va,
      input logic [COORD_W-1:0] vb, input logic [SPEED_W-1:0] ms);
    axis_t             a;
    logic [DIFF_W-1:0] v, av, de, dl, me, ml;
    logic [DIFF_W:0]   cd, hs, mcd;
    v   = {va[COORD_W-1], va} - {vb[COORD_W-1], vb};
    av  = v[DIFF_W-1] ? -v : v;
    a.is_static = (av == '0) || (av < {{(DIFF_W-SPEED_W){1'b0}}, ms});
    cd  = ({{2{amin[COORD_W-1]}}, amin} + {{2{amax[COORD_W-1]}}, amax})
        - ({{2{bmin[COORD_W-1]}}, bmin} + {{2{bmax[COORD_W-1]}}, bmax});
    hs  = ({{2{amax[COORD_W-1]}}, amax} - {{2{amin[COORD_W-1]}}, amin})
        + ({{2{bmax[COORD_W-1]}}, bmax} - {{2{bmin[COORD_W-1]}}, bmin});
    mcd = cd[DIFF_W] ? -cd : cd;
    a.ok = a.is_static ? (!hs[DIFF_W] && (mcd < hs)) : 1'b1;
    de  = {bmin[COORD_W-1], bmin} - {amax[COORD_W-1], amax};
    dl  = {bmax[COORD_W-1], bmax} - {amin[COORD_W-1], amin};
    me  = de[DIFF_W-1] ? -de : de;
    ml  = dl[DIFF_W-1] ? -dl : dl;
    a.ne    = {me, {FRAC_BITS{1'b0}}};
    a.nl    = {ml, {FRAC_BITS{1'b0}}};
    a.neg_e = de[DIFF_W-1] ^ v[DIFF_W-1];
    a.neg_l = dl[DIFF_W-1] ^ v[DIFF_W-1];
    // keep the divider clean on static axes; its result is not used there
    a.den   = a.is_static ? {{(DIFF_W-1){1'b0}}, 1'b1} : av;
    axis_prep = a;
  endfunction

  axis_t ax_x, ax_y;
  always_comb begin
    ax_x = axis_prep(in_ch.a_min_x, in_ch.a_max_x, in_ch.b_min_x, in_ch.b_max_x,
                     in_ch.a_vel_x, in_ch.b_vel_x, min_speed_r);
    ax_y = axis_prep(in_ch.a_min_y, in_ch.a_max_y, in_ch.b_min_y, in_ch.b_max_y,
                     in_ch.a_vel_y, in_ch.b_vel_y, min_speed_r);
  end

  logic              vld_r  [DIV_STEPS+1];
  side_t             side_r [DIV_STEPS+1];
  logic [REM_W-1:0]  rem_r  [DIV_STEPS+1][LANES];
  logic [NQ_W-1:0]   nq_r   [DIV_STEPS+1][LANES];
  logic [DIFF_W-1:0] den_r  [DIV_STEPS+1][LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= '{x_static: ax_x.is_static, x_ok: ax_x.ok,
                     y_static: ax_y.is_static, y_ok: ax_y.ok,
                     neg: {ax_y.neg_l, ax_y.neg_e, ax_x.neg_l, ax_x.neg_e}};
      nq_r[0][LANE_XE]  <= ax_x.ne;
      nq_r[0][LANE_XL]  <= ax_x.nl;
      nq_r[0][LANE_YE]  <= ax_y.ne;
      nq_r[0][LANE_YL]  <= ax_y.nl;
      den_r[0][LANE_XE] <= ax_x.den;
      den_r[0][LANE_XL] <= ax_x.den;
      den_r[0][LANE_YE] <= ax_y.den;
      den_r[0][LANE_YL] <= ax_y.den;
      for (int l = 0; l < LANES; l++) rem_r[0][l] <= '0;
    end
  end

  // ---------------- divider stages: one quotient bit each ----------------
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [REM_W-1:0] rs_nxt  [LANES];
    logic             ge_nxt  [LANES];

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        rs_nxt[l] = {rem_r[k][l][REM_W-2:0], nq_r[k][l][NQ_W-1]};
        ge_nxt[l] = rs_nxt[l] >= {1'b0, den_r[k][l]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k+1] <= side_r[k];
        for (int l = 0; l < LANES; l++) begin
          rem_r[k+1][l] <= ge_nxt[l] ? rs_nxt[l] - {1'b0, den_r[k][l]} : rs_nxt[l];
          nq_r[k+1][l]  <= {nq_r[k][l][NQ_W-2:0], ge_nxt[l]};
          den_r[k+1][l] <= den_r[k][l];
        end
      end
    end
  end

  // ---------------- saturate and order ----------------
  logic signed [COORD_W-1:0] q_nxt [LANES];
  logic signed [COORD_W-1:0] frame_s;
  logic signed [COORD_W-1:0] xlo_nxt, xhi_nxt, ylo_nxt, yhi_nxt;
  logic signed [COORD_W-1:0] xlo_r, xhi_r, ylo_r, yhi_r;
  logic                      ok_r, post_vld_r;

  assign frame_s = $signed({1'b0, frame_time_r});

  always_comb begin
    for (int l = 0; l < LANES; l++)
      q_nxt[l] = sat_q(nq_r[DIV_STEPS][l], side_r[DIV_STEPS].neg[l]);
    if (side_r[DIV_STEPS].x_static) begin
      xlo_nxt = '0;
      xhi_nxt = frame_s;
    end else if (q_nxt[LANE_XE] < q_nxt[LANE_XL]) begin
      xlo_nxt = q_nxt[LANE_XE];
      xhi_nxt = q_nxt[LANE_XL];
    end else begin
      xlo_nxt = q_nxt[LANE_XL];
      xhi_nxt = q_nxt[LANE_XE];
    end
    if (side_r[DIV_STEPS].y_static) begin
      ylo_nxt = '0;
      yhi_nxt = frame_s;
    end else if (q_nxt[LANE_YE] < q_nxt[LANE_YL]) begin
      ylo_nxt = q_nxt[LANE_YE];
      yhi_nxt = q_nxt[LANE_YL];
    end else begin
      ylo_nxt = q_nxt[LANE_YL];
      yhi_nxt = q_nxt[LANE_YE];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      post_vld_r <= 1'b0;
    end else if (en) begin
      post_vld_r <= vld_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xlo_r <= xlo_nxt;
      xhi_r <= xhi_nxt;
      ylo_r <= ylo_nxt;
      yhi_r <= yhi_nxt;
      ok_r  <= side_r[DIV_STEPS].x_ok && side_r[DIV_STEPS].y_ok;
    end
  end

  // ---------------- intersect and output register ----------------
  logic signed [COORD_W-1:0] lo_nxt, hi_nxt;
  logic                      hit_nxt;
  logic [TIME_W-1:0]         t_nxt;
  logic                      hit_r;
  logic [TIME_W-1:0]         t_r;

  always_comb begin
    lo_nxt  = (xlo_r > ylo_r) ? xlo_r : ylo_r;
    hi_nxt  = (xhi_r < yhi_r) ? xhi_r : yhi_r;
    hit_nxt = ok_r && (hi_nxt >= lo_nxt) && ((lo_nxt > 0) || (hi_nxt > 0));
    t_nxt   = (hit_nxt && (lo_nxt > 0)) ? lo_nxt[TIME_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= post_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= hit_nxt;
      t_r   <= t_nxt;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.hit          = hit_r;
  assign out_ch.contact_time = t_r;

  // ---------------- assertions ----------------
  a_no_time_without_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !hit_r) |-> (t_r == '0))
    else $error("contact time set without a hit");

  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready == (!out_vld_r || out_ch.ready))
    else $error("input ready out of step with output stall");

  a_stall_holds_tail: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(post_vld_r) && $stable(vld_r[DIV_STEPS])))
    else $error("pipeline moved during stall");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> vld_r[0])
    else $error("accepted beat lost at pipeline entry");

  a_hit_positive_window: assert property (@(posedge clk) disable iff (!rst_n)
    (post_vld_r && en && hit_nxt) |-> ok_r)
    else $error("hit reported on excluded static axis");

endmodule
